>>> rtl/epr_pkg.sv
package epr_pkg;

   // default width of the tick and echo time counters
   localparam int TIME_BITS_DEF = 24;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int CFG_W       = 24;
   localparam int DIV_W       = 16;
   localparam int NUM_LIMITS  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_HOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_PER_UNIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_0      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_1      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_2      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_3      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_4      = 3'd7;

   // register reset values
   localparam logic [CFG_W-1:0] RST_TRIGGER_HOLD = 24'd10;
   localparam logic [CFG_W-1:0] RST_TIMEOUT      = 24'd30000;
   localparam logic [DIV_W-1:0] RST_TIME_PER_UNIT = 16'd58;
   localparam logic [CFG_W-1:0] RST_LIMIT_0      = 24'd5;
   localparam logic [CFG_W-1:0] RST_LIMIT_1      = 24'd10;
   localparam logic [CFG_W-1:0] RST_LIMIT_2      = 24'd20;
   localparam logic [CFG_W-1:0] RST_LIMIT_3      = 24'd100;
   localparam logic [CFG_W-1:0] RST_LIMIT_4      = 24'd400;

   // distance classes
   localparam int CLASS_W = 3;
   localparam logic [CLASS_W-1:0] CLASS_TOO_CLOSE  = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_VERY_CLOSE = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_CLOSE      = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_FAR        = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_VERY_FAR   = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_UNKNOWN    = 3'd5;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

>>> rtl/epr_ctrl.sv
module epr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  epr_pkg::status_type status,
   output epr_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/epr_dp.sv
module epr_dp #(
   parameter int TIME_BITS = epr_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [epr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [epr_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               req_echo_level,
   input  epr_pkg::cmd_type                   cmd,
   output epr_pkg::status_type                status,
   output logic                               rsp_trigger_level,
   output logic                               rsp_measure_done,
   output logic [epr_pkg::CLASS_W-1:0]        rsp_distance_class
);

   localparam int WB    = (TIME_BITS > epr_pkg::CFG_W) ? TIME_BITS : epr_pkg::CFG_W;
   localparam int CNT_W = $clog2(TIME_BITS);
   localparam int DW    = epr_pkg::DIV_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 1);
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   localparam logic [1:0] PH_READY   = 2'd0;
   localparam logic [1:0] PH_WAIT    = 2'd1;
   localparam logic [1:0] PH_MEASURE = 2'd2;

   // configuration registers
   logic [epr_pkg::CFG_W-1:0] hold_ff;
   logic [epr_pkg::CFG_W-1:0] timeout_ff;
   logic [DW-1:0]             tpu_ff;
   logic [epr_pkg::CFG_W-1:0] lim_ff [epr_pkg::NUM_LIMITS];

   // sequencer state
   logic [1:0]           phase_ff, phase_in;
   logic [TIME_BITS-1:0] ticks_ff, ticks_in;
   logic [TIME_BITS-1:0] echo_ff, echo_in;
   logic                 trig_ff, trig_in;
   logic                 done_ff, done_in;
   logic [TIME_BITS-1:0] elapsed;

   // divider
   logic [DW-1:0]        rem_ff;
   logic [TIME_BITS-1:0] quo_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DW:0]          shifted;
   logic [DW+1:0]        diff;
   logic                 ge;

   // classifier
   logic [epr_pkg::CLASS_W-1:0] class_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff    <= epr_pkg::RST_TRIGGER_HOLD;
         timeout_ff <= epr_pkg::RST_TIMEOUT;
         tpu_ff     <= epr_pkg::RST_TIME_PER_UNIT;
         lim_ff[0]  <= epr_pkg::RST_LIMIT_0;
         lim_ff[1]  <= epr_pkg::RST_LIMIT_1;
         lim_ff[2]  <= epr_pkg::RST_LIMIT_2;
         lim_ff[3]  <= epr_pkg::RST_LIMIT_3;
         lim_ff[4]  <= epr_pkg::RST_LIMIT_4;
      end else if (csr_valid) begin
         case (csr_index)
            epr_pkg::CSR_TRIGGER_HOLD:  hold_ff    <= csr_data;
            epr_pkg::CSR_TIMEOUT:       timeout_ff <= csr_data;
            epr_pkg::CSR_TIME_PER_UNIT: tpu_ff     <= csr_data[DW-1:0];
            epr_pkg::CSR_LIMIT_0:       lim_ff[0]  <= csr_data;
            epr_pkg::CSR_LIMIT_1:       lim_ff[1]  <= csr_data;
            epr_pkg::CSR_LIMIT_2:       lim_ff[2]  <= csr_data;
            epr_pkg::CSR_LIMIT_3:       lim_ff[3]  <= csr_data;
            epr_pkg::CSR_LIMIT_4:       lim_ff[4]  <= csr_data;
            default: ;
         endcase
      end
   end

   // one tick of the trigger and echo sequencer
   always_comb begin
      elapsed  = (ticks_ff == TIME_MAX) ? ticks_ff : ticks_ff + 1'b1;
      phase_in = phase_ff;
      ticks_in = elapsed;
      echo_in  = echo_ff;
      trig_in  = trig_ff;
      done_in  = 1'b0;
      if (WB'(elapsed) > WB'(timeout_ff)) begin
         // timeout: drop the measurement and restart
         echo_in  = '0;
         trig_in  = 1'b1;
         ticks_in = '0;
         phase_in = PH_READY;
         done_in  = 1'b1;
      end else begin
         case (phase_ff)
            PH_READY: begin
               if (WB'(elapsed) > WB'(hold_ff)) begin
                  trig_in  = 1'b0;
                  phase_in = PH_WAIT;
               end
            end
            PH_WAIT: begin
               if (req_echo_level) begin
                  ticks_in = '0;
                  phase_in = PH_MEASURE;
               end
            end
            PH_MEASURE: begin
               if (!req_echo_level) begin
                  echo_in  = elapsed;
                  trig_in  = 1'b1;
                  ticks_in = '0;
                  phase_in = PH_READY;
                  done_in  = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_READY;
         ticks_ff <= '0;
         echo_ff  <= '0;
         trig_ff  <= 1'b1;
         done_ff  <= 1'b0;
      end else if (cmd.load) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         echo_ff  <= echo_in;
         trig_ff  <= trig_in;
         done_ff  <= done_in;
      end
   end

   // restoring divider step, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[TIME_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, tpu_ff};
   assign ge      = !diff[DW+1];
   assign status.div_last = (cnt_ff == CNT_LAST);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= '0;
         quo_ff <= echo_in;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= ge ? diff[DW-1:0] : shifted[DW-1:0];
         quo_ff <= {quo_ff[TIME_BITS-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // first limit above the distance wins
   always_comb begin
      class_in = epr_pkg::CLASS_UNKNOWN;
      for (int k = epr_pkg::NUM_LIMITS - 1; k >= 0; k--) begin
         if (WB'(quo_ff) < WB'(lim_ff[k])) begin
            class_in = epr_pkg::CLASS_W'(k);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_trigger_level  <= trig_ff;
         rsp_measure_done   <= done_ff;
         rsp_distance_class <= class_in;
      end
   end

endmodule

>>> rtl/echo_pulse_range_classifier.sv
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req_echo_level
// rsp       out        rsp_valid / rsp_ready   rsp_trigger_level, rsp_measure_done,
//                                              rsp_distance_class
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// a beat is accepted only when the previous one has been divided and its result emitted; the
// bit-serial restoring divider makes one quotient bit a cycle.
// reset is synchronous and restores register defaults, trigger high and tick and echo counters zero.
// a finished result waits in the output register; the next beat is taken meanwhile
// and its result is held back until rsp_ready frees the register.
// csr_ready is always high.
module echo_pulse_range_classifier #(
   parameter int TIME_BITS = epr_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_echo_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_trigger_level,
   output logic                            rsp_measure_done,
   output logic [epr_pkg::CLASS_W-1:0]     rsp_distance_class,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [epr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [epr_pkg::CSR_DATA_W-1:0]  csr_data
);

   epr_pkg::cmd_type    cmd;
   epr_pkg::status_type status;

   assign csr_ready = 1'b1;

   // handshake and sequencing control
   epr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // ranger state, divider and classifier
   epr_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_echo_level     (req_echo_level),
      .cmd                (cmd),
      .status             (status),
      .rsp_trigger_level  (rsp_trigger_level),
      .rsp_measure_done   (rsp_measure_done),
      .rsp_distance_class (rsp_distance_class)
   );

`ifndef SYNTHESIS
   // one beat in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input beat taken while busy");

   // a finished measurement always restarts with the trigger raised
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_measure_done |-> rsp_trigger_level)
      else $error("measurement done without trigger restart");

   // class code stays in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance_class <= epr_pkg::CLASS_UNKNOWN)
      else $error("distance class out of range");

   // a result is only produced for an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without a pending beat");
`endif

endmodule
